// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/lbd_pkg.sv =====
// ---------------------------------------------------------------------------
// lbd_pkg
// Types and constants shared by the ladder button debouncer.
// ---------------------------------------------------------------------------
package lbd_pkg;

   localparam int SAMPLE_W = 12;
   localparam int THRESH_W = 13;
   localparam int LEN_W    = 8;
   localparam int CODE_W   = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   localparam logic [CODE_W-1:0] IDLE_CODE = 3'd7;

   // Register map
   localparam logic [CSR_IDX_W-1:0] REG_THRESH_0     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE_LEN = 3'd6;

   localparam logic [THRESH_W-1:0] THRESH_RST [6] = '{
      13'd500, 13'd1200, 13'd1900, 13'd2600, 13'd3200, 13'd3700
   };
   localparam logic [LEN_W-1:0] DEBOUNCE_LEN_RST = 8'd3;

   typedef struct packed {
      logic              press_event;
      logic [CODE_W-1:0] button_index;
   } result_type;

endpackage

// ===== rtl/lbd_req_if.sv =====
// ---------------------------------------------------------------------------
// lbd_req_if
// Sample channel: one converter reading per beat.
// ---------------------------------------------------------------------------
interface lbd_req_if;
   logic                         valid;
   logic                         ready;
   logic [lbd_pkg::SAMPLE_W-1:0] adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

// ===== rtl/lbd_rsp_if.sv =====
// ---------------------------------------------------------------------------
// lbd_rsp_if
// Result channel: one press report per beat.
// ---------------------------------------------------------------------------
interface lbd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       press_event;
   logic [lbd_pkg::CODE_W-1:0] button_index;

   modport source (output valid, output press_event, output button_index, input ready);
   modport sink   (input valid, input press_event, input button_index, output ready);
endinterface

// ===== rtl/lbd_csr_if.sv =====
// ---------------------------------------------------------------------------
// lbd_csr_if
// Register write channel: index and data per beat.
// ---------------------------------------------------------------------------
interface lbd_csr_if;
   logic                           valid;
   logic                           ready;
   logic [lbd_pkg::CSR_IDX_W-1:0]  index;
   logic [lbd_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/lbd_decode.sv =====
// ---------------------------------------------------------------------------
// lbd_decode
// Ladder decode: lowest button whose threshold exceeds the sample, else idle.
// ---------------------------------------------------------------------------
module lbd_decode #(
   parameter int BUTTONS = 6
) (
   input  logic [lbd_pkg::SAMPLE_W-1:0] sample,
   input  logic [lbd_pkg::THRESH_W-1:0] thresh [BUTTONS],
   output logic [lbd_pkg::CODE_W-1:0]   code
);

   always_comb begin
      code = lbd_pkg::IDLE_CODE;
      for (int i = BUTTONS - 1; i >= 0; i--) begin
         if ({1'b0, sample} < thresh[i]) begin
            code = lbd_pkg::CODE_W'(i);
         end
      end
   end

endmodule

// ===== rtl/ladder_button_debouncer.sv =====
// ---------------------------------------------------------------------------
// ladder_button_debouncer
// Resistor-ladder button decoder with run-length debounce and press events.
// ---------------------------------------------------------------------------
// Takes one sample per clock unless stalled and returns one result beat per
// sample: the sample is held in an input register, then decoded and
// debounced in a single pass into the result register. Back-pressure on the
// result channel stalls the input side only when both registers are full.
// Registers 0..5 are the ladder thresholds (only the first BUTTONS are used),
// register 6 is the debounce run length; write them while idle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ladder_button_debouncer #(
   parameter int BUTTONS = 6
) (
   input  logic       clock,
   input  logic       reset,
   lbd_req_if.sink    req_bus,
   lbd_rsp_if.source  rsp_bus,
   lbd_csr_if.sink    csr_bus
);

   logic [lbd_pkg::THRESH_W-1:0] thresh_ff [BUTTONS];
   logic [lbd_pkg::LEN_W-1:0]    len_ff;

   logic                         smp_valid_ff;
   logic [lbd_pkg::SAMPLE_W-1:0] smp_ff;

   logic                         rsp_valid_ff;
   lbd_pkg::result_type          rsp_ff;
   lbd_pkg::result_type          rsp_in;

   logic [lbd_pkg::CODE_W-1:0]   last_ff, last_in;
   logic [lbd_pkg::LEN_W-1:0]    count_ff, count_in;
   logic [lbd_pkg::CODE_W-1:0]   conf_ff, conf_in;
   logic [lbd_pkg::CODE_W-1:0]   rep_ff, rep_in;

   logic [lbd_pkg::CODE_W-1:0]   code;
   logic                         step;
   logic                         press;
   logic                         csr_wr;

   // Config registers
   assign csr_bus.ready = 1'b1;
   assign csr_wr        = csr_bus.valid & csr_bus.ready;

   for (genvar g = 0; g < BUTTONS; g++) begin : g_thresh
      always_ff @(posedge clock) begin
         if (reset) begin
            thresh_ff[g] <= lbd_pkg::THRESH_RST[g];
         end else if (csr_wr && csr_bus.index == lbd_pkg::REG_THRESH_0 +
                      lbd_pkg::CSR_IDX_W'(g)) begin
            thresh_ff[g] <= csr_bus.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= lbd_pkg::DEBOUNCE_LEN_RST;
      end else if (csr_wr && csr_bus.index == lbd_pkg::REG_DEBOUNCE_LEN) begin
         len_ff <= csr_bus.data[lbd_pkg::LEN_W-1:0];
      end
   end

   // Pipeline control
   assign step          = smp_valid_ff & (~rsp_valid_ff | rsp_bus.ready);
   assign req_bus.ready = ~smp_valid_ff | step;

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_bus.ready) begin
            smp_valid_ff <= req_bus.valid;
         end
         if (~rsp_valid_ff | rsp_bus.ready) begin
            rsp_valid_ff <= smp_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         smp_ff <= req_bus.adc_sample;
      end
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   lbd_decode #(
      .BUTTONS (BUTTONS)
   ) u_decode (
      .sample (smp_ff),
      .thresh (thresh_ff),
      .code   (code)
   );

   // Debounce and press tracking
   always_comb begin
      last_in = code;
      if (code == last_ff) begin
         count_in = (count_ff < len_ff) ? count_ff + 1'b1 : count_ff;
      end else begin
         count_in = lbd_pkg::LEN_W'(1);
      end
      conf_in = (count_in >= len_ff) ? code : conf_ff;
      press   = (conf_in != lbd_pkg::IDLE_CODE) && (conf_in != rep_ff);
      priority if (press) begin
         rep_in = conf_in;
      end else if (conf_in == lbd_pkg::IDLE_CODE) begin
         rep_in = lbd_pkg::IDLE_CODE;
      end else begin
         rep_in = rep_ff;
      end
      rsp_in.press_event  = press;
      rsp_in.button_index = press ? conf_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= lbd_pkg::IDLE_CODE;
         count_ff <= '0;
         conf_ff  <= lbd_pkg::IDLE_CODE;
         rep_ff   <= lbd_pkg::IDLE_CODE;
      end else if (step) begin
         last_ff  <= last_in;
         count_ff <= count_in;
         conf_ff  <= conf_in;
         rep_ff   <= rep_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.press_event  = rsp_ff.press_event;
   assign rsp_bus.button_index = rsp_ff.button_index;

   // Checks
   `ASSERT_IMPLIES(a_idx_zero_no_press, clock, reset,
                   rsp_valid_ff && !rsp_ff.press_event, rsp_ff.button_index == '0)
   `ASSERT_IMPLIES(a_idx_in_range, clock, reset,
                   rsp_valid_ff && rsp_ff.press_event,
                   rsp_ff.button_index < lbd_pkg::CODE_W'(BUTTONS))
   `ASSERT_NEXT(a_press_marks_reported, clock, reset,
                step && press, rep_ff == conf_ff && rep_ff != lbd_pkg::IDLE_CODE)
   `ASSERT_NEXT(a_run_nonzero, clock, reset, step && len_ff != '0, count_ff != '0)
   `ASSERT_NEXT(a_stall_holds_rsp, clock, reset,
                rsp_valid_ff && !rsp_bus.ready, rsp_valid_ff && $stable(rsp_ff))

endmodule
